[src/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition");

`endif

[src/frhc_pkg.sv]
`timescale 1ns / 1ps

package frhc_pkg;

    localparam logic [63:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;
    // prime = 2^40 + 0x1B3
    localparam int          FNV_PRIME_SHIFT = 40;
    localparam logic [8:0]  FNV_PRIME_LO = 9'h1B3;

    localparam logic [1:0] MODE_TAG   = 2'd0;
    localparam logic [1:0] MODE_BODY  = 2'd1;
    localparam logic [1:0] MODE_CLOSE = 2'd2;

    // close: 8 beat bytes + 4 organ bytes, then 16 link bytes
    localparam int REC_ROUNDS  = 12;
    localparam int LINK_ROUNDS = 16;
    localparam int CNT_W       = 4;

    typedef struct packed {
        logic [63:0] record_digest;
        logic [63:0] link_digest;
        logic        status;
    } t_result;

endpackage

[src/frhc_if.sv]
`timescale 1ns / 1ps

interface frhc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [7:0]  data_byte;
    logic [63:0] beat;
    logic [31:0] organ;

    modport source (output valid, mode, data_byte, beat, organ, input ready);
    modport sink   (input valid, mode, data_byte, beat, organ, output ready);
endinterface

interface frhc_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] record_digest;
    logic [63:0] link_digest;
    logic        status;

    modport source (output valid, record_digest, link_digest, status, input ready);
    modport sink   (input valid, record_digest, link_digest, status, output ready);
endinterface

[src/frhc_round.sv]
`timescale 1ns / 1ps

// One FNV-1a round: (h ^ b) * prime, mod 2^64.
module frhc_round (
    input  logic [63:0] i_hash,
    input  logic [7:0]  i_byte,
    output logic [63:0] o_hash
);

    logic [63:0] w_x;
    logic [63:0] w_lo;

    assign w_x  = i_hash ^ {56'd0, i_byte};
    assign w_lo = w_x * {55'd0, frhc_pkg::FNV_PRIME_LO};
    assign o_hash = {w_x[63-frhc_pkg::FNV_PRIME_SHIFT:0], {frhc_pkg::FNV_PRIME_SHIFT{1'b0}}}
                  + w_lo;

endmodule

[src/frhc_core.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module frhc_core #(
    parameter int TAG_CAPACITY  = 32,
    parameter int BODY_CAPACITY = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    frhc_in_if.sink            i_in,
    output logic               o_res_vld,
    output frhc_pkg::t_result  o_res,
    input  logic               i_res_free
);

    localparam int TAG_W  = $clog2(TAG_CAPACITY);
    localparam int BODY_W = $clog2(BODY_CAPACITY + 1);
    localparam logic [TAG_W-1:0]  TAG_LAST = TAG_W'(TAG_CAPACITY - 1);
    localparam logic [BODY_W-1:0] BODY_CAP = BODY_W'(BODY_CAPACITY);

    typedef enum logic [1:0] {S_IDLE, S_REC, S_LINK, S_PUSH} t_state;

    t_state                       r_state;
    logic [63:0]                  r_acc;
    logic [63:0]                  r_prev;
    logic [63:0]                  r_rec;
    logic [63:0]                  r_link;
    logic                         r_err;
    logic [127:0]                 r_sh;
    logic [frhc_pkg::CNT_W-1:0]   r_cnt;
    logic [TAG_W-1:0]             r_tag_cnt;
    logic [BODY_W-1:0]            r_body_cnt;
    logic                         r_too_long;

    logic [7:0]  w_byte;
    logic [63:0] w_round;
    logic        w_take;

    always_comb begin
        case (r_state)
            S_REC:   w_byte = r_sh[7:0];
            S_LINK:  w_byte = r_sh[127:120];
            default: w_byte = i_in.data_byte;
        endcase
    end

    frhc_round u_round (
        .i_hash (r_acc),
        .i_byte (w_byte),
        .o_hash (w_round)
    );

    assign i_in.ready = (r_state == S_IDLE);
    assign w_take     = i_in.valid && i_in.ready;

    assign o_res_vld           = (r_state == S_PUSH);
    assign o_res.record_digest = r_rec;
    assign o_res.link_digest   = r_link;
    assign o_res.status        = r_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_acc      <= frhc_pkg::FNV_BASIS;
            r_prev     <= '0;
            r_cnt      <= '0;
            r_tag_cnt  <= '0;
            r_body_cnt <= '0;
            r_too_long <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_take) begin
                        case (i_in.mode)
                            frhc_pkg::MODE_TAG: begin
                                if (r_body_cnt == '0 && !r_too_long
                                    && r_tag_cnt < TAG_LAST) begin
                                    if (i_in.data_byte == 8'd0) begin
                                        // zero byte ends the tag
                                        r_tag_cnt <= TAG_LAST;
                                    end else begin
                                        r_acc     <= w_round;
                                        r_tag_cnt <= r_tag_cnt + TAG_W'(1);
                                    end
                                end
                            end
                            frhc_pkg::MODE_BODY: begin
                                if (r_body_cnt < BODY_CAP) begin
                                    r_acc      <= w_round;
                                    r_body_cnt <= r_body_cnt + BODY_W'(1);
                                end else begin
                                    r_too_long <= 1'b1;
                                end
                            end
                            frhc_pkg::MODE_CLOSE: begin
                                r_tag_cnt  <= '0;
                                r_body_cnt <= '0;
                                r_too_long <= 1'b0;
                                r_cnt      <= '0;
                                if (r_too_long) begin
                                    r_acc   <= frhc_pkg::FNV_BASIS;
                                    r_rec   <= '0;
                                    r_link  <= '0;
                                    r_err   <= 1'b1;
                                    r_state <= S_PUSH;
                                end else begin
                                    r_sh    <= {32'd0, i_in.organ, i_in.beat};
                                    r_err   <= 1'b0;
                                    r_state <= S_REC;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_REC: begin
                    // beat then organ, little-endian
                    r_sh <= {8'd0, r_sh[127:8]};
                    r_cnt <= r_cnt + frhc_pkg::CNT_W'(1);
                    r_acc <= w_round;
                    if (r_cnt == frhc_pkg::CNT_W'(frhc_pkg::REC_ROUNDS - 1)) begin
                        r_rec   <= w_round;
                        r_acc   <= frhc_pkg::FNV_BASIS;
                        r_sh    <= {r_prev, w_round};
                        r_cnt   <= '0;
                        r_state <= S_LINK;
                    end
                end
                S_LINK: begin
                    // previous then current, big-endian
                    r_sh  <= {r_sh[119:0], 8'd0};
                    r_cnt <= r_cnt + frhc_pkg::CNT_W'(1);
                    r_acc <= w_round;
                    if (r_cnt == frhc_pkg::CNT_W'(frhc_pkg::LINK_ROUNDS - 1)) begin
                        r_link  <= w_round;
                        r_prev  <= r_rec;
                        r_acc   <= frhc_pkg::FNV_BASIS;
                        r_cnt   <= '0;
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (i_res_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `ASSERT_CLK(a_res_hold, i_clk, i_rst_n,
        o_res_vld && !i_res_free |=> o_res_vld && $stable(o_res))
    `ASSERT_CLK(a_err_zero, i_clk, i_rst_n,
        o_res_vld && o_res.status |-> o_res.record_digest == '0 && o_res.link_digest == '0)
    `ASSERT_CLK(a_link_basis, i_clk, i_rst_n,
        r_state == S_LINK && r_cnt == '0 |-> r_acc == frhc_pkg::FNV_BASIS)
    `ASSERT_NEVER(a_ready_pending, i_clk, i_rst_n, i_in.ready && o_res_vld)

endmodule

[src/fnv1a_record_hash_chain_top.sv]
`timescale 1ns / 1ps

// FNV-1a 64 record hash chain. Requests on i_in carry a mode: tag byte, body
// byte, or close (with 64-bit beat and 32-bit organ). Tag and body bytes are
// folded into the running record digest as each is taken; tag bytes stop
// counting at TAG_CAPACITY-1, at a zero byte, or once the body has started.
// A close folds the beat and organ little-endian (12 rounds), then builds the
// link digest over the previous and the new record digest big-endian
// (16 rounds), all on a single FNV round unit, so a close holds i_in.ready
// low through the record rounds, the link rounds and the push state before
// the next request is taken (longer if the result register is still full). A
// body longer than BODY_CAPACITY makes the close return status 1 with zero
// digests and leaves the chain untouched. Every close returns one result
// request on o_out through an output register; byte requests return none,
// and mode 3 is dropped.
module fnv1a_record_hash_chain_top #(
    parameter int TAG_CAPACITY  = 32,
    parameter int BODY_CAPACITY = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    frhc_in_if.sink     i_in,
    frhc_out_if.source  o_out
);

    logic              w_res_vld;
    logic              w_res_free;
    frhc_pkg::t_result w_res;

    logic              r_out_vld;
    frhc_pkg::t_result r_out;

    frhc_core #(
        .TAG_CAPACITY  (TAG_CAPACITY),
        .BODY_CAPACITY (BODY_CAPACITY)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .o_res_vld  (w_res_vld),
        .o_res      (w_res),
        .i_res_free (w_res_free)
    );

    // output register frees up in the same cycle it is drained
    assign w_res_free = !r_out_vld || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            if (w_res_vld && w_res_free) begin
                r_out_vld <= 1'b1;
                r_out     <= w_res;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out.valid         = r_out_vld;
    assign o_out.record_digest = r_out.record_digest;
    assign o_out.link_digest   = r_out.link_digest;
    assign o_out.status        = r_out.status;

endmodule
